### src/nsfe_pkg.sv
// ----------------------------------------------------------------------------
// nsfe_pkg
// Shared constants and types for the NMEA sentence field extractor.
// ----------------------------------------------------------------------------
package nsfe_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int MAX_FIELDS_DEF = 31;

  localparam int HEADER_W = 40;
  localparam logic [HEADER_W-1:0] HEADER_RESET = 40'h474E524D43;  // "GNRMC"

  localparam int MANT_W = 35;
  localparam int FNUM_W = 5;
  localparam int FRAC_W = 4;
  localparam int PAIR_W = 7;
  localparam int TDATA_W = 80;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    logic absorb;
    logic clear;
  } nsfe_ctrl_t;

  typedef struct packed {
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        frac;
    logic [7:0]               lead;
    logic [PAIR_W-1:0]        pair_first;
    logic [PAIR_W-1:0]        pair_second;
    logic [PAIR_W-1:0]        pair_third;
    logic                     empty;
    logic                     overflow;
  } nsfe_field_t;

endpackage

### src/nsfe_field_acc.sv
// ----------------------------------------------------------------------------
// nsfe_field_acc
// Per-field accumulator: number value, fraction count, lead character and
// the three two-digit pairs of the field being received.
// ----------------------------------------------------------------------------
module nsfe_field_acc #(
  parameter int MAX_DIGITS = nsfe_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsfe_pkg::nsfe_ctrl_t ctrl,
  input  logic [7:0]           rx_char,
  output nsfe_pkg::nsfe_field_t field
);
  import nsfe_pkg::*;

  localparam int ACC_W  = 4 * MAX_DIGITS;
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  logic [3:0]        char_pos, char_pos_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [DCNT_W-1:0] dcnt, dcnt_next;
  logic [DCNT_W-1:0] frac, frac_next;
  logic              minus, minus_next;
  logic              point, point_next;
  logic              stopped, stopped_next;
  logic              ovf, ovf_next;
  logic [7:0]        lead, lead_next;
  logic [PAIR_W-1:0] pv [3];
  logic [PAIR_W-1:0] pv_next [3];
  logic [2:0]        blk, blk_next;

  logic                     dig;
  logic [3:0]               d;
  logic [ACC_W+MANT_W-1:0]  acc_ext;
  logic [MANT_W-1:0]        mag;

  always_comb begin
    dig = rx_char inside {[CH_ZERO:CH_NINE]};
    d   = dig ? 4'(rx_char - CH_ZERO) : 4'd0;

    char_pos_next = char_pos;
    acc_next      = acc;
    dcnt_next     = dcnt;
    frac_next     = frac;
    minus_next    = minus;
    point_next    = point;
    stopped_next  = stopped;
    ovf_next      = ovf;
    lead_next     = lead;
    blk_next      = blk;
    for (int j = 0; j < 3; j++) begin
      pv_next[j] = pv[j];
    end

    if (ctrl.clear) begin
      char_pos_next = '0;
      acc_next      = '0;
      dcnt_next     = '0;
      frac_next     = '0;
      minus_next    = 1'b0;
      point_next    = 1'b0;
      stopped_next  = 1'b0;
      ovf_next      = 1'b0;
      lead_next     = '0;
      blk_next      = '0;
      for (int j = 0; j < 3; j++) begin
        pv_next[j] = '0;
      end
    end else if (ctrl.absorb) begin
      if (char_pos == 4'd0) begin
        lead_next = rx_char;
      end
      for (int j = 0; j < 3; j++) begin
        if (char_pos[3:1] == 3'(j)) begin
          if (!char_pos[0]) begin
            pv_next[j]  = PAIR_W'(d);
            blk_next[j] = !dig;
          end else if (!blk[j] && dig) begin
            pv_next[j] = PAIR_W'((pv[j] << 3) + (pv[j] << 1) + PAIR_W'(d));
          end
        end
      end
      if (!stopped) begin
        if (char_pos == 4'd0 && (rx_char == CH_MINUS || rx_char == CH_PLUS)) begin
          minus_next = (rx_char == CH_MINUS);
        end else if (dig) begin
          if (!point && acc == '0 && d == 4'd0) begin
            acc_next = acc;  // leading zero
          end else if (dcnt < DCNT_W'(MAX_DIGITS)) begin
            acc_next  = (acc << 3) + (acc << 1) + ACC_W'(d);
            dcnt_next = dcnt + 1'b1;
            if (point) begin
              frac_next = frac + 1'b1;
            end
          end else begin
            ovf_next = 1'b1;
          end
        end else if (rx_char == CH_POINT && !point) begin
          point_next = 1'b1;
        end else begin
          stopped_next = 1'b1;
        end
      end
      if (char_pos != 4'd15) begin
        char_pos_next = char_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= '0;
      acc      <= '0;
      dcnt     <= '0;
      frac     <= '0;
      minus    <= 1'b0;
      point    <= 1'b0;
      stopped  <= 1'b0;
      ovf      <= 1'b0;
      lead     <= '0;
      blk      <= '0;
      for (int j = 0; j < 3; j++) begin
        pv[j] <= '0;
      end
    end else begin
      char_pos <= char_pos_next;
      acc      <= acc_next;
      dcnt     <= dcnt_next;
      frac     <= frac_next;
      minus    <= minus_next;
      point    <= point_next;
      stopped  <= stopped_next;
      ovf      <= ovf_next;
      lead     <= lead_next;
      blk      <= blk_next;
      for (int j = 0; j < 3; j++) begin
        pv[j] <= pv_next[j];
      end
    end
  end

  always_comb begin
    acc_ext = {{MANT_W{1'b0}}, acc};
    mag     = acc_ext[MANT_W-1:0];
    field.mantissa    = minus ? -$signed(mag) : $signed(mag);
    field.frac        = FRAC_W'(frac);
    field.lead        = lead;
    field.pair_first  = pv[0];
    field.pair_second = pv[1];
    field.pair_third  = pv[2];
    field.empty       = (char_pos == 4'd0);
    field.overflow    = ovf;
  end

endmodule

### src/nmea_sentence_field_extractor.sv
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor
// Finds '$' plus a configured five-character header in a byte stream and
// reports each comma-separated field with its decoded value and pairs.
// ----------------------------------------------------------------------------
// A field result appears in the cycle after its closing delimiter.
// Throughput: one byte per cycle; the output register is refilled while
// being drained, so tready only drops when a result waits unaccepted.
// Reset: synchronous rst returns to waiting for '$' and restores the
// header register to GNRMC.
module nmea_sentence_field_extractor #(
  parameter int MAX_DIGITS = nsfe_pkg::MAX_DIGITS_DEF,
  parameter int MAX_FIELDS = nsfe_pkg::MAX_FIELDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nsfe_pkg::HEADER_W-1:0]  cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // field_number, value_mantissa, fraction_digits, lead_char, pair_first,
  // pair_second, pair_third, field_empty, digits_overflow, zero pad
  output logic [nsfe_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast    // last_field
);
  import nsfe_pkg::*;

  localparam int FIELD_W = $clog2(MAX_FIELDS + 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_FIELDS = 2'd2;

  logic [HEADER_W-1:0] header;
  logic [1:0]          phase, phase_next;
  logic [2:0]          hpos, hpos_next;
  logic [FIELD_W-1:0]  cur_field, cur_field_next;
  logic                out_valid;
  logic [TDATA_W-1:0]  out_data;
  logic                out_last;

  logic        accept;
  logic        term;
  logic        emit;
  logic        emit_last;
  logic [2:0]  hidx;
  logic [7:0]  want;
  nsfe_ctrl_t  ctrl;
  nsfe_field_t field;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hidx = 3'd4 - hpos;
    want = header[{hidx, 3'b000} +: 8];
    term = (s_axis_tdata == CH_STAR) || (s_axis_tdata < CH_SPACE) ||
           (s_axis_tdata > CH_LC_Z);

    phase_next     = phase;
    hpos_next      = hpos;
    cur_field_next = cur_field;
    emit           = 1'b0;
    emit_last      = 1'b0;
    ctrl.absorb    = 1'b0;

    if (accept) begin
      if (s_axis_tdata == CH_DOLLAR) begin
        phase_next     = PH_HEADER;
        hpos_next      = '0;
        cur_field_next = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (s_axis_tdata == want) begin
              hpos_next = hpos + 1'b1;
              if (hpos == 3'd4) begin
                phase_next     = PH_FIELDS;
                cur_field_next = '0;
              end
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_FIELDS: begin
            if (cur_field == '0) begin
              if (term) begin
                phase_next = PH_IDLE;
              end else if (s_axis_tdata == CH_COMMA) begin
                cur_field_next = FIELD_W'(1);
              end
            end else if (term) begin
              emit       = 1'b1;
              emit_last  = 1'b1;
              phase_next = PH_IDLE;
            end else if (s_axis_tdata == CH_COMMA) begin
              emit      = 1'b1;
              emit_last = (cur_field >= FIELD_W'(MAX_FIELDS));
              if (emit_last) begin
                phase_next = PH_IDLE;
              end else begin
                cur_field_next = cur_field + 1'b1;
              end
            end else begin
              ctrl.absorb = 1'b1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
    ctrl.clear = accept && !ctrl.absorb;
  end

  nsfe_field_acc #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_field_acc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rx_char (s_axis_tdata),
    .field   (field)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header    <= HEADER_RESET;
      phase     <= PH_IDLE;
      hpos      <= '0;
      cur_field <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        header <= cfg_wdata;
      end
      phase     <= phase_next;
      hpos      <= hpos_next;
      cur_field <= cur_field_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {5'b0, field.overflow, field.empty, field.pair_third,
                   field.pair_second, field.pair_first, field.lead, field.frac,
                   field.mantissa, FNUM_W'(cur_field)};
      out_last <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

endmodule

### tb/sv/tb_nmea_sentence_field_extractor.sv
// ----------------------------------------------------------------------------
// tb_nmea_sentence_field_extractor
// Drives NMEA text bytes into the field extractor under several sentence
// headers, decodes every byte in a local copy of the field parser and checks
// each field result, in order and field by field, against it or dir_tab.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_field_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import nsfe_pkg::*;

  localparam int MAX_DIG     = MAX_DIGITS_DEF;
  localparam int MAX_FLD     = MAX_FIELDS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 100;
  localparam int NUM_PHASES  = 6;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_HEADER, SCAN_FIELDS} scan_phase_e;

  typedef struct packed {
    logic [4:0]        fnum;
    logic signed [34:0] mant;
    logic [3:0]        frac;
    logic [7:0]        lead;
    logic [6:0]        p1;
    logic [6:0]        p2;
    logic [6:0]        p3;
    logic              empty;
    logic              ovf;
    logic              last;
  } field_result_t;

  typedef struct {
    string         text;
    bit            fixed;
    field_result_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [HEADER_W-1:0] cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tlast;

  nmea_sentence_field_extractor u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser copy
  scan_phase_e     scan_ph;
  logic [39:0]     hdr_cfg;
  int              hdr_pos;
  int              fld_num;
  int              chr_pos;
  int              dig_cnt;
  int              frac_cnt;
  longint unsigned acc;
  bit              neg;
  bit              pnt;
  bit              stop;
  bit              ovf;
  logic [7:0]      lead_hold;
  int              pair_v [3];
  bit              pair_blk [3];

  field_result_t   pending_fields [$];
  logic [7:0]      line_q [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  bit              idle_mode;
  bit              hold_req = 1'b0;
  field_result_t   mon_got;
  field_result_t   mon_want;

  task automatic clear_field_state();
    chr_pos   = 0;
    acc       = 0;
    dig_cnt   = 0;
    neg       = 1'b0;
    pnt       = 1'b0;
    stop      = 1'b0;
    frac_cnt  = 0;
    lead_hold = 8'h00;
    ovf       = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pair_v[k]   = 0;
      pair_blk[k] = 1'b0;
    end
  endtask

  task automatic absorb_char(input logic [7:0] c);
    bit dig;
    int d;
    int k;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d = dig ? int'(c) - int'(CH_ZERO) : 0;
    if (chr_pos == 0) lead_hold = c;
    if (chr_pos < 6) begin
      k = chr_pos / 2;
      if (chr_pos % 2 == 0) begin
        pair_v[k]   = d;
        pair_blk[k] = !dig;
      end else if (!pair_blk[k] && dig) begin
        pair_v[k] = pair_v[k] * 10 + d;
      end
    end
    if (!stop) begin
      if (chr_pos == 0 && (c == CH_MINUS || c == CH_PLUS)) begin
        neg = (c == CH_MINUS);
      end else if (dig) begin
        // leading zeros before the point are dropped
        if (pnt || acc != 0 || d != 0) begin
          if (dig_cnt < MAX_DIG) begin
            acc = acc * 10 + d;
            dig_cnt++;
            if (pnt) frac_cnt++;
          end else begin
            ovf = 1'b1;
          end
        end
      end else if (c == CH_POINT && !pnt) begin
        pnt = 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
    if (chr_pos < 15) chr_pos++;
  endtask

  function automatic field_result_t make_result(input bit last);
    field_result_t   r;
    longint unsigned v;
    v = acc;
    if (neg && v != 0) v = -v;
    r.fnum  = fld_num[4:0];
    r.mant  = v[34:0];
    r.frac  = frac_cnt[3:0];
    r.lead  = lead_hold;
    r.p1    = pair_v[0][6:0];
    r.p2    = pair_v[1][6:0];
    r.p3    = pair_v[2][6:0];
    r.empty = (chr_pos == 0);
    r.ovf   = ovf;
    r.last  = last;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, output bit got, output field_result_t r);
    bit term;
    bit last;
    got = 1'b0;
    r = '0;
    if (b == CH_DOLLAR) begin
      scan_ph = SCAN_HEADER;
      hdr_pos = 0;
      fld_num = 0;
      clear_field_state();
    end else if (scan_ph == SCAN_HEADER) begin
      if (b == hdr_cfg[8*(4 - hdr_pos % 5) +: 8]) begin
        hdr_pos++;
        if (hdr_pos >= 5) begin
          scan_ph = SCAN_FIELDS;
          fld_num = 0;
          clear_field_state();
        end
      end else begin
        scan_ph = SCAN_IDLE;
      end
    end else if (scan_ph == SCAN_FIELDS) begin
      term = (b == CH_STAR) || (b < CH_SPACE) || (b > CH_LC_Z);
      if (fld_num == 0) begin
        if (term) begin
          scan_ph = SCAN_IDLE;
        end else if (b == CH_COMMA) begin
          fld_num = 1;
          clear_field_state();
        end
      end else if (term) begin
        r = make_result(1'b1);
        got = 1'b1;
        scan_ph = SCAN_IDLE;
      end else if (b == CH_COMMA) begin
        last = (fld_num >= MAX_FLD);
        r = make_result(last);
        got = 1'b1;
        if (last) begin
          scan_ph = SCAN_IDLE;
        end else begin
          fld_num++;
          clear_field_state();
        end
      end else begin
        absorb_char(b);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit fixed, input field_result_t want);
    int            gap;
    bit            got;
    field_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, got, r);
    if (got) pending_fields.push_back(fixed ? want : r);
  endtask

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_LC_Z));
    while (c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR);
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_char(input int n);
    return (n < 10) ? CH_ZERO + 8'(n) : 8'h41 + 8'(n - 10);
  endfunction

  task automatic add_field();
    int    kind;
    int    n;
    string mix;
    mix = "0123456789.-+ A";
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
      end
      1, 2, 3, 4: begin
        if ($urandom_range(0, 2) == 0) line_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(CH_ZERO);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
        repeat (n) line_q.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          line_q.push_back(CH_POINT);
          repeat ($urandom_range(0, 5)) line_q.push_back(rand_digit());
        end
        if ($urandom_range(0, 7) == 0) line_q.push_back(rand_text_char());
      end
      5: begin
        repeat (6) line_q.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          line_q.push_back(CH_POINT);
          repeat (2) line_q.push_back(rand_digit());
        end
      end
      6: repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      7: repeat ($urandom_range(1, 8)) line_q.push_back(rand_text_char());
      8: repeat ($urandom_range(1, 7)) line_q.push_back(mix[$urandom_range(0, mix.len() - 1)]);
      default: repeat ($urandom_range(10, 18)) line_q.push_back(rand_text_char());
    endcase
  endtask

  task automatic add_terminator();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      line_q.push_back(CH_STAR);
      line_q.push_back(hex_char($urandom_range(0, 15)));
      line_q.push_back(hex_char($urandom_range(0, 15)));
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
    end else if (r < 8) begin
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
    end else if (r < 9) begin
      line_q.push_back(8'($urandom_range(8'h7B, 8'hFF)));
    end else begin
      line_q.push_back(8'($urandom_range(8'h00, 8'h1F)));
    end
  endtask

  task automatic build_sentence();
    int         kind;
    int         k;
    int         nf;
    logic [7:0] c;
    line_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      line_q.push_back(CH_DOLLAR);
      k = $urandom_range(0, 4);
      for (int i = 0; i < k; i++) line_q.push_back(hdr_cfg[8*(4 - i) +: 8]);
      c = hdr_cfg[8*(4 - k) +: 8];
      c[$urandom_range(0, 7)] ^= 1'b1;
      line_q.push_back(c);
      line_q.push_back(CH_COMMA);
      add_field();
      line_q.push_back(CH_COMMA);
      add_terminator();
    end else begin
      line_q.push_back(CH_DOLLAR);
      for (int i = 0; i < 5; i++) line_q.push_back(hdr_cfg[8*(4 - i) +: 8]);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(rand_text_char());
      if ($urandom_range(0, 19) == 0) begin
        add_terminator();
      end else begin
        line_q.push_back(CH_COMMA);
        nf = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 12);
        for (int f = 0; f < nf; f++) begin
          add_field();
          if ($urandom_range(0, 39) == 0) line_q.push_back(CH_DOLLAR);
          if (f < nf - 1) line_q.push_back(CH_COMMA);
        end
        add_terminator();
      end
    end
  endtask

  task automatic check_item(input string nm, input logic signed [63:0] w,
                            input logic signed [63:0] a);
    if (w !== a) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm, w, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got.fnum  = m_axis_tdata[4:0];
      mon_got.mant  = m_axis_tdata[39:5];
      mon_got.frac  = m_axis_tdata[43:40];
      mon_got.lead  = m_axis_tdata[51:44];
      mon_got.p1    = m_axis_tdata[58:52];
      mon_got.p2    = m_axis_tdata[65:59];
      mon_got.p3    = m_axis_tdata[72:66];
      mon_got.empty = m_axis_tdata[73];
      mon_got.ovf   = m_axis_tdata[74];
      mon_got.last  = m_axis_tlast;
      if (pending_fields.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected field result, expected none actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        mon_want = pending_fields.pop_front();
        check_item("field_number", mon_want.fnum, mon_got.fnum);
        check_item("value_mantissa", mon_want.mant, mon_got.mant);
        check_item("fraction_digits", mon_want.frac, mon_got.frac);
        check_item("lead_char", mon_want.lead, mon_got.lead);
        check_item("pair_first", mon_want.p1, mon_got.p1);
        check_item("pair_second", mon_want.p2, mon_got.p2);
        check_item("pair_third", mon_want.p3, mon_got.p3);
        check_item("field_empty", mon_want.empty, mon_got.empty);
        check_item("digits_overflow", mon_want.ovf, mon_got.ovf);
        check_item("last_field", mon_want.last, mon_got.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int v;
    int d;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_mode) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        v = ($urandom_range(0, 9) < 7);
        if (v) d = $urandom_range(1, 20);
        else d = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        m_axis_tready <= v[0];
        repeat (d) @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t   dir_tab [4];
    logic [39:0] hdr_plan [NUM_PHASES];
    logic [39:0] rnd_hdr;
    int          sent;
    bit          fixed;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    idle_mode     = 1'b1;

    hdr_cfg = HEADER_RESET;
    scan_ph = SCAN_IDLE;
    hdr_pos = 0;
    fld_num = 0;
    clear_field_state();

    dir_tab[0] = '{text: "$GNRMC,", fixed: 1'b0, want: '0};
    dir_tab[1] = '{text: ",", fixed: 1'b1,
                   want: '{fnum: 5'd1, empty: 1'b1, default: '0}};
    dir_tab[2] = '{text: "-99999999999,", fixed: 1'b1,
                   want: '{fnum: 5'd2, mant: -35'sd9999999999, lead: CH_MINUS,
                           p2: 7'd99, p3: 7'd99, ovf: 1'b1, default: '0}};
    dir_tab[3] = '{text: "12.5\377", fixed: 1'b0, want: '0};

    rnd_hdr = 40'({$urandom, $urandom});
    for (int i = 0; i < 5; i++)
      if (rnd_hdr[8*i +: 8] == CH_DOLLAR) rnd_hdr[8*i +: 8] = 8'h41;
    hdr_plan = '{HEADER_RESET, 40'h0, 40'hFF_FFFF_FFFF, 40'h4750474741, rnd_hdr, HEADER_RESET};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      for (int i = 0; i < dir_tab[r].text.len(); i++) begin
        fixed = dir_tab[r].fixed && (i == dir_tab[r].text.len() - 1);
        push_byte(dir_tab[r].text[i], fixed, dir_tab[r].want);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        while (pending_fields.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hdr_plan[ph];
        @(posedge clk);
        cfg_we    <= 1'b0;
        hdr_cfg = hdr_plan[ph];
      end
      idle_mode = (ph != 3);
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_sentence();
        sent += line_q.size();
        foreach (line_q[i]) push_byte(line_q[i], 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    while (pending_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
